@@ hdl/tmc_pkg.sv @@
`timescale 1ns / 1ps

package tmc_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int MODE_W = 3;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int POS_W  = 11;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT        = 3'd0,
      MODE_BACKSPACE  = 3'd1,
      MODE_CLEAR      = 3'd2,
      MODE_SET_CURSOR = 3'd3,
      MODE_READ       = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic exec;
      logic copy_rd;
      logic copy_wr;
      logic fill_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scroll_needed;
      logic clear_needed;
      logic copy_last;
      logic fill_last;
   } status_type;

endpackage

@@ hdl/tmc_req_if.sv @@
`timescale 1ns / 1ps

interface tmc_req_if;
   logic                        valid;
   logic                        ready;
   logic [tmc_pkg::MODE_W-1:0]  mode;
   logic [tmc_pkg::CHAR_W-1:0]  char_code;
   logic [tmc_pkg::ROW_W-1:0]   row;
   logic [tmc_pkg::COL_W-1:0]   col;

   modport source (output valid, mode, char_code, row, col, input ready);
   modport sink   (input valid, mode, char_code, row, col, output ready);
endinterface

@@ hdl/tmc_rsp_if.sv @@
`timescale 1ns / 1ps

interface tmc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tmc_pkg::ROW_W-1:0]   cur_row;
   logic [tmc_pkg::COL_W-1:0]   cur_col;
   logic [tmc_pkg::POS_W-1:0]   cursor_position;
   logic [tmc_pkg::CELL_W-1:0]  cell_value;

   modport source (output valid, cur_row, cur_col, cursor_position, cell_value,
                   input ready);
   modport sink   (input valid, cur_row, cur_col, cursor_position, cell_value,
                   output ready);
endinterface

@@ hdl/tmc_ram.sv @@
`timescale 1ns / 1ps

module tmc_ram #(
   parameter  int WIDTH  = 16,
   parameter  int DEPTH  = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tmc_datapath.sv @@
`timescale 1ns / 1ps

module tmc_datapath #(
   parameter int COLUMNS = tmc_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmc_pkg::DEFAULT_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tmc_pkg::cmd_type            cmd,
   output tmc_pkg::status_type         status,
   input  logic [tmc_pkg::MODE_W-1:0]  req_mode,
   input  logic [tmc_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tmc_pkg::ROW_W-1:0]   req_row,
   input  logic [tmc_pkg::COL_W-1:0]   req_col,
   input  logic                        csr_wr_en,
   input  logic [tmc_pkg::ATTR_W-1:0]  csr_wr_data,
   output logic [tmc_pkg::ROW_W-1:0]   rsp_cur_row,
   output logic [tmc_pkg::COL_W-1:0]   rsp_cur_col,
   output logic [tmc_pkg::POS_W-1:0]   rsp_cursor_position,
   output logic [tmc_pkg::CELL_W-1:0]  rsp_cell_value
);

   localparam int ROW_W    = tmc_pkg::ROW_W;
   localparam int COL_W    = tmc_pkg::COL_W;
   localparam int POS_W    = tmc_pkg::POS_W;
   localparam int CELL_W   = tmc_pkg::CELL_W;
   localparam int CELLS    = ROWS * COLUMNS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CALC_W   = (ADDR_W > POS_W) ? ADDR_W : POS_W;
   localparam int COPY_END = (ROWS - 1) * COLUMNS - 1;

   localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
   localparam logic [COL_W:0]    COLS_X   = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LINE_OFS = ADDR_W'(COLUMNS);

   logic [ROW_W-1:0]           cur_row_ff, cur_row_in;
   logic [COL_W-1:0]           cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0]          cnt_ff, cnt_in;
   logic                       is_read_ff, is_read_in;
   logic [tmc_pkg::ATTR_W-1:0] attr_ff;

   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [CELL_W-1:0] rsp_cell_ff;

   logic [ROW_W-1:0]  req_row_c;
   logic [COL_W-1:0]  req_col_c;
   logic [CALC_W-1:0] cur_pos;
   logic [CALC_W-1:0] req_pos;
   logic [CELL_W-1:0] blank;
   logic              is_newline;
   logic              at_origin;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   assign req_row_c = ({1'b0, req_row} >= ROWS_X) ? LAST_ROW : req_row;
   assign req_col_c = ({1'b0, req_col} >= COLS_X) ? LAST_COL : req_col;

   assign cur_pos = CALC_W'(cur_row_ff) * CALC_W'(COLUMNS) + CALC_W'(cur_col_ff);
   assign req_pos = CALC_W'(req_row_c) * CALC_W'(COLUMNS) + CALC_W'(req_col_c);

   assign blank      = {attr_ff, tmc_pkg::SPACE_CODE};
   assign is_newline = (req_char_code == tmc_pkg::NEWLINE_CODE);
   assign at_origin  = (cur_row_ff == '0) && (cur_col_ff == '0);

   assign status.scroll_needed = (req_mode == tmc_pkg::MODE_PUT)
                               && (is_newline || (cur_col_ff == LAST_COL))
                               && (cur_row_ff == LAST_ROW);
   assign status.clear_needed  = (req_mode == tmc_pkg::MODE_CLEAR);
   assign status.copy_last     = (cnt_ff == ADDR_W'(COPY_END));
   assign status.fill_last     = (cnt_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      cnt_in     = cnt_ff;
      is_read_in = is_read_ff;
      wr_en      = 1'b0;
      wr_addr    = cnt_ff;
      wr_data    = blank;
      rd_en      = 1'b0;
      rd_addr    = cnt_ff + LINE_OFS;
      if (cmd.exec) begin
         cnt_in     = '0;
         is_read_in = (req_mode == tmc_pkg::MODE_READ);
         case (req_mode)
            tmc_pkg::MODE_PUT: begin
               if (!is_newline) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_pos[ADDR_W-1:0];
                  wr_data = {attr_ff, req_char_code};
               end
               if (is_newline || (cur_col_ff == LAST_COL)) begin
                  cur_col_in = '0;
                  // the scroll keeps the cursor on the bottom row
                  if (cur_row_ff != LAST_ROW) begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
            tmc_pkg::MODE_BACKSPACE: begin
               if (!at_origin) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_pos[ADDR_W-1:0] - 1'b1;
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - 1'b1;
                  end else begin
                     cur_row_in = cur_row_ff - 1'b1;
                     cur_col_in = LAST_COL;
                  end
               end
            end
            tmc_pkg::MODE_CLEAR: begin
               cur_row_in = '0;
               cur_col_in = '0;
            end
            tmc_pkg::MODE_SET_CURSOR: begin
               cur_row_in = req_row_c;
               cur_col_in = req_col_c;
            end
            tmc_pkg::MODE_READ: begin
               rd_en   = 1'b1;
               rd_addr = req_pos[ADDR_W-1:0];
            end
            default: begin
            end
         endcase
      end
      if (cmd.copy_rd) begin
         rd_en = 1'b1;
      end
      if (cmd.copy_wr) begin
         wr_en   = 1'b1;
         wr_data = rd_data;
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.fill_wr) begin
         wr_en  = 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         cnt_ff     <= '0;
         is_read_ff <= 1'b0;
         attr_ff    <= tmc_pkg::ATTR_RESET;
      end else begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         cnt_ff     <= cnt_in;
         is_read_ff <= is_read_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_row_ff  <= cur_row_ff;
         rsp_col_ff  <= cur_col_ff;
         rsp_pos_ff  <= cur_pos[POS_W-1:0];
         rsp_cell_ff <= is_read_ff ? rd_data : '0;
      end
   end

   tmc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_cur_row         = rsp_row_ff;
   assign rsp_cur_col         = rsp_col_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_value      = rsp_cell_ff;

endmodule

@@ hdl/tmc_ctrl.sv @@
`timescale 1ns / 1ps

module tmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tmc_pkg::status_type  status,
   output tmc_pkg::cmd_type     cmd
);

   tmc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.clear_needed) begin
                  state_in = tmc_pkg::ST_FILL;
               end else if (status.scroll_needed) begin
                  state_in = tmc_pkg::ST_COPY_RD;
               end else begin
                  state_in = tmc_pkg::ST_DONE;
               end
            end
         end
         tmc_pkg::ST_COPY_RD: state_in = tmc_pkg::ST_COPY_WR;
         tmc_pkg::ST_COPY_WR: begin
            // after the last copied line the counter sits at the bottom row
            state_in = status.copy_last ? tmc_pkg::ST_FILL : tmc_pkg::ST_COPY_RD;
         end
         tmc_pkg::ST_FILL: begin
            if (status.fill_last) begin
               state_in = tmc_pkg::ST_DONE;
            end
         end
         tmc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tmc_pkg::ST_IDLE;
            end
         end
         default: state_in = tmc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         tmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.exec  = req_valid;
         end
         tmc_pkg::ST_COPY_RD: cmd.copy_rd = 1'b1;
         tmc_pkg::ST_COPY_WR: cmd.copy_wr = 1'b1;
         tmc_pkg::ST_FILL:    cmd.fill_wr = 1'b1;
         tmc_pkg::ST_DONE:    cmd.rsp_load = out_free;
         default: begin
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/text_mode_console_engine.sv @@
`timescale 1ns / 1ps
// Put character, newline, backspace, set cursor and read cell: the item is taken in the
// idle state and the output register is loaded in the done state once the output is free;
// no new item is taken until the result is loaded, and a stalled result holds it back. A scroll
// adds a read and a write per copied cell, then one write per blank cell of the bottom row;
// clear adds one write per cell.
// Reset homes the cursor, sets the attribute to 0x0F; the screen is garbage until cleared.

module text_mode_console_engine #(
   parameter int COLUMNS = tmc_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmc_pkg::DEFAULT_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   tmc_req_if.sink                    req_bus,
   tmc_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [tmc_pkg::ATTR_W-1:0] csr_wr_data
);

   tmc_pkg::cmd_type    cmd;
   tmc_pkg::status_type status;

   tmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmc_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_bus.mode),
      .req_char_code       (req_bus.char_code),
      .req_row             (req_bus.row),
      .req_col             (req_bus.col),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_cur_row         (rsp_bus.cur_row),
      .rsp_cur_col         (rsp_bus.cur_col),
      .rsp_cursor_position (rsp_bus.cursor_position),
      .rsp_cell_value      (rsp_bus.cell_value)
   );

   // a transfer in starts work, so the block is busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input taken while an item is still in flight");

   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((int'(rsp_bus.cur_row) < ROWS)
                         && (int'(rsp_bus.cur_col) < COLUMNS)))
      else $error("reported cursor outside the screen");

   a_position_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.cursor_position
         == tmc_pkg::POS_W'(int'(rsp_bus.cur_row) * COLUMNS
                            + int'(rsp_bus.cur_col))))
      else $error("cursor position disagrees with row and column");

endmodule

@@ tb/sv/text_mode_console_engine_tb.sv @@
`timescale 1ns / 1ps

module text_mode_console_engine_tb;

   localparam int COLS        = tmc_pkg::DEFAULT_COLUMNS;
   localparam int ROWS        = tmc_pkg::DEFAULT_ROWS;
   localparam int CELLS       = COLS * ROWS;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 165;
   localparam int SCRIPT_LEN  = 25;

   // Modes outside the command set; the block must ignore them.
   localparam logic [tmc_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
   localparam logic [tmc_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [tmc_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      logic [tmc_pkg::MODE_W-1:0] mode;
      logic [tmc_pkg::CHAR_W-1:0] char_code;
      logic [tmc_pkg::ROW_W-1:0]  row;
      logic [tmc_pkg::COL_W-1:0]  col;
   } command_type;

   typedef struct {
      logic [tmc_pkg::ROW_W-1:0]  cur_row;
      logic [tmc_pkg::COL_W-1:0]  cur_col;
      logic [tmc_pkg::POS_W-1:0]  cursor_position;
      logic [tmc_pkg::CELL_W-1:0] cell_value;
   } report_type;

   typedef struct {
      command_type cmd;
      bit          has_want;
      report_type  want;
   } script_row_type;

   localparam report_type UNCHECKED = '{'0, '0, '0, '0};

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [tmc_pkg::ATTR_W-1:0] csr_wr_data;

   tmc_req_if req_bus ();
   tmc_rsp_if rsp_bus ();

   text_mode_console_engine #(
      .COLUMNS (COLS),
      .ROWS    (ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the console state.
   logic [tmc_pkg::CELL_W-1:0] shadow_screen [CELLS];
   int                         shadow_row;
   int                         shadow_col;
   logic [tmc_pkg::ATTR_W-1:0] shadow_attr;

   report_type console_reports [$];
   int         mismatches  = 0;
   int         cycle_count = 0;
   int         req_gap_pct = 0;
   int         rsp_stall_pct = 0;

   function automatic void advance_row();
      shadow_row++;
      if (shadow_row >= ROWS) begin
         for (int i = 0; i < (ROWS - 1) * COLS; i++)
            shadow_screen[i] = shadow_screen[i + COLS];
         for (int c = 0; c < COLS; c++)
            shadow_screen[(ROWS - 1) * COLS + c] = {shadow_attr, tmc_pkg::SPACE_CODE};
         shadow_row = ROWS - 1;
      end
   endfunction

   function automatic report_type console_apply(command_type cmd);
      report_type rep;
      int         r;
      int         c;
      r = (int'(cmd.row) >= ROWS) ? ROWS - 1 : int'(cmd.row);
      c = (int'(cmd.col) >= COLS) ? COLS - 1 : int'(cmd.col);
      rep.cell_value = '0;
      case (cmd.mode)
         tmc_pkg::MODE_PUT: begin
            if (cmd.char_code == tmc_pkg::NEWLINE_CODE) begin
               shadow_col = 0;
               advance_row();
            end else begin
               shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, cmd.char_code};
               shadow_col++;
               if (shadow_col >= COLS) begin
                  shadow_col = 0;
                  advance_row();
               end
            end
         end
         tmc_pkg::MODE_BACKSPACE: begin
            if (shadow_row != 0 || shadow_col != 0) begin
               if (shadow_col > 0) begin
                  shadow_col--;
               end else begin
                  shadow_row--;
                  shadow_col = COLS - 1;
               end
               shadow_screen[shadow_row * COLS + shadow_col] =
                  {shadow_attr, tmc_pkg::SPACE_CODE};
            end
         end
         tmc_pkg::MODE_CLEAR: begin
            foreach (shadow_screen[i]) shadow_screen[i] = {shadow_attr, tmc_pkg::SPACE_CODE};
            shadow_row = 0;
            shadow_col = 0;
         end
         tmc_pkg::MODE_SET_CURSOR: begin
            shadow_row = r;
            shadow_col = c;
         end
         tmc_pkg::MODE_READ: rep.cell_value = shadow_screen[r * COLS + c];
         default: ;
      endcase
      rep.cur_row         = shadow_row[tmc_pkg::ROW_W-1:0];
      rep.cur_col         = shadow_col[tmc_pkg::COL_W-1:0];
      rep.cursor_position = tmc_pkg::POS_W'(shadow_row * COLS + shadow_col);
      return rep;
   endfunction

   function automatic command_type random_command();
      command_type cmd;
      int          pick;
      pick = $urandom_range(0, 99);
      cmd.char_code = tmc_pkg::CHAR_W'($urandom_range(0, 255));
      cmd.row       = tmc_pkg::ROW_W'($urandom_range(0, 31));
      cmd.col       = tmc_pkg::COL_W'($urandom_range(0, 127));
      // Lean on the bottom-right corner so wraps and scrolls get exercised.
      if ($urandom_range(0, 3) == 0) begin
         cmd.row = tmc_pkg::ROW_W'($urandom_range(ROWS - 2, 31));
         cmd.col = tmc_pkg::COL_W'($urandom_range(COLS - 3, 127));
      end
      if (pick < 50) begin
         cmd.mode = tmc_pkg::MODE_PUT;
         if ($urandom_range(0, 99) < 7) cmd.char_code = tmc_pkg::NEWLINE_CODE;
      end else if (pick < 62) begin
         cmd.mode = tmc_pkg::MODE_BACKSPACE;
      end else if (pick < 64) begin
         cmd.mode = tmc_pkg::MODE_CLEAR;
      end else if (pick < 76) begin
         cmd.mode = tmc_pkg::MODE_SET_CURSOR;
      end else if (pick < 95) begin
         cmd.mode = tmc_pkg::MODE_READ;
      end else begin
         cmd.mode = tmc_pkg::MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      end
      return cmd;
   endfunction

   task automatic send_command(input command_type cmd, input bit has_want,
                               input report_type want);
      int         gap;
      report_type predicted;
      gap = 0;
      while ($urandom_range(0, 99) < req_gap_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= cmd.mode;
      req_bus.char_code <= cmd.char_code;
      req_bus.row       <= cmd.row;
      req_bus.col       <= cmd.col;
      do @(posedge clock); while (!req_bus.ready);
      predicted = console_apply(cmd);
      console_reports.push_back(has_want ? want : predicted);
   endtask

   // Hold off the sender until every outstanding report has come back.
   task automatic drain_reports();
      if (console_reports.size() != 0) begin
         req_bus.valid <= 1'b0;
         while (console_reports.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_attribute(input logic [tmc_pkg::ATTR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_attr = value;
   endtask

   task automatic check_report();
      report_type want;
      if (console_reports.size() == 0) begin
         $display("%0t: report with nothing outstanding: row %0d col %0d pos %0d cell %h",
                  $time, rsp_bus.cur_row, rsp_bus.cur_col,
                  rsp_bus.cursor_position, rsp_bus.cell_value);
         mismatches++;
      end else begin
         want = console_reports.pop_front();
         if (rsp_bus.cur_row !== want.cur_row ||
             rsp_bus.cur_col !== want.cur_col ||
             rsp_bus.cursor_position !== want.cursor_position ||
             rsp_bus.cell_value !== want.cell_value) begin
            $display(
               "%0t: expected row %0d col %0d pos %0d cell %h, got row %0d col %0d pos %0d cell %h",
               $time, want.cur_row, want.cur_col, want.cursor_position,
               want.cell_value, rsp_bus.cur_row, rsp_bus.cur_col,
               rsp_bus.cursor_position, rsp_bus.cell_value);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_report();
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL text_mode_console_engine");
      $finish;
   end

   initial begin : stimulus
      script_row_type             script [SCRIPT_LEN];
      logic [tmc_pkg::ATTR_W-1:0] phase_attr [PHASES];

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = tmc_pkg::MODE_PUT;
      req_bus.char_code = '0;
      req_bus.row       = '0;
      req_bus.col       = '0;
      shadow_row        = 0;
      shadow_col        = 0;
      shadow_attr       = tmc_pkg::ATTR_RESET;

      phase_attr = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'hFF};
      phase_attr[4] = tmc_pkg::ATTR_W'($urandom_range(0, 255));

      // Clear comes right after the first set-cursor; nothing reads the screen before it.
      script = '{
         '{'{tmc_pkg::MODE_SET_CURSOR, 8'h00, 5'd31, 7'd127},
           1'b1, '{5'd24, 7'd79, 11'd1999, 16'h0000}},
         '{'{tmc_pkg::MODE_CLEAR,      8'h00, 5'd0,  7'd0},
           1'b1, '{5'd0,  7'd0,  11'd0,    16'h0000}},
         '{'{tmc_pkg::MODE_BACKSPACE,  8'h00, 5'd0,  7'd0},
           1'b1, '{5'd0,  7'd0,  11'd0,    16'h0000}},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd0,  7'd0},
           1'b1, '{5'd0,  7'd0,  11'd0,    16'h0F20}},
         '{'{tmc_pkg::MODE_PUT,        8'hFF, 5'd0,  7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_PUT,        8'h00, 5'd0,  7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd0,  7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd0,  7'd1},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_BACKSPACE,  8'h00, 5'd0,  7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd0,  7'd1},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_SET_CURSOR, 8'h00, 5'd1,  7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_BACKSPACE,  8'h00, 5'd0,  7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd0,  7'd79},  1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_PUT, tmc_pkg::NEWLINE_CODE, 5'd0, 7'd0}, 1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_SET_CURSOR, 8'h00, 5'd24, 7'd79},  1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_PUT,        8'h41, 5'd0,  7'd0},
           1'b1, '{5'd24, 7'd0,  11'd1920, 16'h0000}},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd23, 7'd79},  1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd24, 7'd0},   1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_PUT, tmc_pkg::NEWLINE_CODE, 5'd0, 7'd0},
           1'b1, '{5'd24, 7'd0, 11'd1920, 16'h0000}},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd31, 7'd127}, 1'b0, UNCHECKED},
         '{'{MODE_SPARE_5,             8'hAA, 5'd21, 7'd85},  1'b0, UNCHECKED},
         '{'{MODE_SPARE_6,             8'h55, 5'd10, 7'd42},  1'b0, UNCHECKED},
         '{'{MODE_SPARE_7,             8'hFF, 5'd31, 7'd127},
           1'b1, '{5'd24, 7'd0, 11'd1920, 16'h0000}},
         '{'{tmc_pkg::MODE_SET_CURSOR, 8'h00, 5'd0,  7'd127}, 1'b0, UNCHECKED},
         '{'{tmc_pkg::MODE_READ,       8'h00, 5'd24, 7'd79},  1'b0, UNCHECKED}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gap_pct   = 33;
      rsp_stall_pct = 65;
      foreach (script[i]) send_command(script[i].cmd, script[i].has_want, script[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_reports();
         write_attribute(phase_attr[phase]);
         case (phase / 2)
            0: begin
               req_gap_pct   = 33;
               rsp_stall_pct = 65;
            end
            1: begin
               req_gap_pct   = 65;
               rsp_stall_pct = 33;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 199) == 0) drain_reports();
            send_command(random_command(), 1'b0, UNCHECKED);
         end
      end

      drain_reports();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS text_mode_console_engine");
      else
         $display("FAIL text_mode_console_engine");
      $finish;
   end

endmodule
